[rtl/dsa_pkg.sv]
`timescale 1ns / 1ps
package dsa_pkg;

	// Slot space and pool geometry
	localparam int SLOTS       = 1024;
	localparam int SW          = $clog2(SLOTS);      // slot index bits
	localparam int PW          = SW + 1;             // pending pointer bits, span 2*SLOTS
	localparam int CNT_W       = SW + 1;             // counts up to SLOTS
	localparam int NUM_CLASSES = 3;
	localparam int CW          = 2;                  // pool class bits
	localparam int MEM_DEPTH   = NUM_CLASSES * SLOTS;
	localparam int AW          = $clog2(MEM_DEPTH);
	localparam int SIZE_W      = 11;
	localparam int RSV_W       = 10;
	localparam int DEF_MAX_BATCHES = 8;

	// Action codes
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_COMMIT = 2'd2;
	localparam logic [1:0] ACT_RETIRE = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_BADFREE = 3'd2;
	localparam logic [2:0] ST_QFULL   = 3'd3;
	localparam logic [2:0] ST_NORET   = 3'd4;

	// Descriptor table commands
	localparam logic [1:0] TOP_NONE   = 2'd0;
	localparam logic [1:0] TOP_BIND   = 2'd1;
	localparam logic [1:0] TOP_UNBIND = 2'd2;

	typedef struct packed {
		logic [NUM_CLASSES-1:0][SIZE_W-1:0] pool_size;
		logic [NUM_CLASSES-1:0][RSV_W-1:0]  reserved;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_step;
		logic latch;
		logic alloc_exec;
		logic alloc_fin;
		logic free_rd;
		logic free_fin;
		logic commit;
		logic ret_empty;
		logic ret_start;
		logic ret_rd;
		logic ret_wr;
		logic ret_next;
		logic ret_fin;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic [1:0] act;
		logic       alloc_recycled;
		logic       bc_zero;
		logic       ret_more;
		logic       ret_last_cls;
	} stat_t;

	// Flat address of a slot in a per-class store
	function automatic logic [AW-1:0] mem_addr(input logic [CW-1:0] cls,
		input logic [SW-1:0] idx);
		mem_addr = AW'(cls) * AW'(SLOTS) + AW'(idx);
	endfunction

endpackage

[rtl/dsa_regs.sv]
`timescale 1ns / 1ps
module dsa_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output dsa_pkg::cfg_t cfg
);
	import dsa_pkg::*;

	localparam logic [2:0] REG_BUF_SIZE = 3'd0;
	localparam logic [2:0] REG_IMG_SIZE = 3'd1;
	localparam logic [2:0] REG_VOL_SIZE = 3'd2;
	localparam logic [2:0] REG_BUF_RSV  = 3'd3;
	localparam logic [2:0] REG_IMG_RSV  = 3'd4;
	localparam logic [2:0] REG_VOL_RSV  = 3'd5;

	logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_q;
	logic [NUM_CLASSES-1:0][RSV_W-1:0]  rsv_q;
	logic [2:0]                         idx;
	logic                               wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				size_q[c] <= SIZE_W'(SLOTS);
				rsv_q[c]  <= '0;
			end
		end else if (wr) begin
			case (idx)
				REG_BUF_SIZE: size_q[0] <= pwdata[SIZE_W-1:0];
				REG_IMG_SIZE: size_q[1] <= pwdata[SIZE_W-1:0];
				REG_VOL_SIZE: size_q[2] <= pwdata[SIZE_W-1:0];
				REG_BUF_RSV:  rsv_q[0]  <= pwdata[RSV_W-1:0];
				REG_IMG_RSV:  rsv_q[1]  <= pwdata[RSV_W-1:0];
				REG_VOL_RSV:  rsv_q[2]  <= pwdata[RSV_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_BUF_SIZE: prdata = 32'(size_q[0]);
			REG_IMG_SIZE: prdata = 32'(size_q[1]);
			REG_VOL_SIZE: prdata = 32'(size_q[2]);
			REG_BUF_RSV:  prdata = 32'(rsv_q[0]);
			REG_IMG_RSV:  prdata = 32'(rsv_q[1]);
			REG_VOL_RSV:  prdata = 32'(rsv_q[2]);
			default:      prdata = '0;
		endcase
	end

	assign cfg.pool_size = size_q;
	assign cfg.reserved  = rsv_q;

endmodule

[rtl/dsa_ctrl.sv]
`timescale 1ns / 1ps
module dsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dsa_pkg::stat_t stat,
	output dsa_pkg::cmd_t  cmd
);
	import dsa_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_EXEC     = 3'd2;
	localparam logic [2:0] S_ALLOC_WB = 3'd3;
	localparam logic [2:0] S_FREE_FIN = 3'd4;
	localparam logic [2:0] S_RET_CHK  = 3'd5;
	localparam logic [2:0] S_RET_WR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.act)
					ACT_ALLOC: begin
						cmd.alloc_exec = 1'b1;
						state_d = stat.alloc_recycled ? S_ALLOC_WB : S_IDLE;
					end
					ACT_FREE: begin
						cmd.free_rd = 1'b1;
						state_d     = S_FREE_FIN;
					end
					ACT_COMMIT: begin
						cmd.commit = 1'b1;
						state_d    = S_IDLE;
					end
					default: begin
						if (stat.bc_zero) begin
							cmd.ret_empty = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.ret_start = 1'b1;
							state_d       = S_RET_CHK;
						end
					end
				endcase
			end
			S_ALLOC_WB: begin
				cmd.alloc_fin = 1'b1;
				state_d       = S_IDLE;
			end
			S_FREE_FIN: begin
				cmd.free_fin = 1'b1;
				state_d      = S_IDLE;
			end
			S_RET_CHK: begin
				if (stat.ret_more) begin
					cmd.ret_rd = 1'b1;
					state_d    = S_RET_WR;
				end else if (stat.ret_last_cls) begin
					cmd.ret_fin = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.ret_next = 1'b1;
				end
			end
			S_RET_WR: begin
				cmd.ret_wr = 1'b1;
				state_d    = S_RET_CHK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

endmodule

[rtl/dsa_datapath.sv]
`timescale 1ns / 1ps
module dsa_datapath #(
	parameter int MAX_BATCHES = dsa_pkg::DEF_MAX_BATCHES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dsa_pkg::cfg_t  cfg,
	input  dsa_pkg::cmd_t  cmd,
	output dsa_pkg::stat_t stat,
	input  logic [1:0]     action,
	input  logic [1:0]     pool_class,
	input  logic [9:0]     slot,
	input  logic [63:0]    resource_handle,
	input  logic [7:0]     sampler_code,
	output logic           done,
	output logic [2:0]     status,
	output logic [9:0]     out_slot,
	output logic [1:0]     table_op,
	output logic [1:0]     table_class,
	output logic [63:0]    bind_handle,
	output logic [7:0]     bind_sampler
);
	import dsa_pkg::*;

	localparam int BW = $clog2(MAX_BATCHES + 1);
	localparam int IW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;

	// Latched word
	logic [1:0]  act_q;
	logic [1:0]  cls_q;
	logic [9:0]  slot_q;
	logic [63:0] handle_q;
	logic [7:0]  samp_q;

	// Per-class control state
	logic [NUM_CLASSES-1:0][CNT_W-1:0] fresh_q;
	logic [NUM_CLASSES-1:0][CNT_W-1:0] rc_q;
	logic [NUM_CLASSES-1:0][PW-1:0]    head_q;
	logic [NUM_CLASSES-1:0][PW-1:0]    tail_q;
	logic [NUM_CLASSES-1:0][PW-1:0]    last_q;
	logic [MAX_BATCHES-1:0][NUM_CLASSES-1:0][PW-1:0] marks_q;
	logic [BW-1:0]  bc_q;
	logic [CW-1:0]  rcls_q;
	logic [AW-1:0]  clr_addr_q;

	// Memories
	logic [SW-1:0] stk_mem [MEM_DEPTH];
	logic [SW-1:0] fifo_mem [MEM_DEPTH];
	logic          bm_mem [MEM_DEPTH];
	logic [SW-1:0] stk_rd_q;
	logic [SW-1:0] fifo_rd_q;
	logic          bm_rd_q;

	logic          stk_we, fifo_we, bm_we, bm_wdata;
	logic [AW-1:0] stk_waddr, fifo_waddr, bm_waddr;
	logic [AW-1:0] stk_raddr, fifo_raddr, bm_raddr;

	// Derived values
	logic              cls_ok;
	logic [CW-1:0]     ci;
	logic [SIZE_W-1:0] size_c, limit;
	logic [SIZE_W:0]   cand;
	logic              fresh_ok, recyc, do_fresh;
	logic [CNT_W-1:0]  rc_dec;
	logic [PW-1:0]     pend_cnt;
	logic              bad;
	logic              any_open, bc_full, do_commit;
	logic              ret_room;

	// Result
	logic        emit;
	logic [2:0]  r_status;
	logic [9:0]  r_slot;
	logic [1:0]  r_op, r_cls;
	logic [63:0] r_handle;
	logic [7:0]  r_samp;

	assign cls_ok   = cls_q < CW'(NUM_CLASSES);
	assign ci       = cls_ok ? cls_q : '0;
	assign size_c   = cfg.pool_size[ci];
	assign limit    = (size_c > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : size_c;
	assign cand     = (SIZE_W+1)'(cfg.reserved[ci]) + (SIZE_W+1)'(fresh_q[ci]);
	assign fresh_ok = cand < (SIZE_W+1)'(limit);
	assign recyc    = cls_ok && (rc_q[ci] != '0);
	assign do_fresh = cls_ok && !recyc && fresh_ok;
	assign rc_dec   = rc_q[ci] - CNT_W'(1);
	assign pend_cnt = tail_q[ci] - head_q[ci];
	assign bad      = !cls_ok || !(PW'(slot_q) < PW'(SLOTS)) || !bm_rd_q ||
	                  (pend_cnt >= PW'(SLOTS));
	assign bc_full  = bc_q >= BW'(MAX_BATCHES);
	assign do_commit = cmd.commit && any_open && !bc_full;
	assign ret_room = rc_q[rcls_q] < CNT_W'(SLOTS);

	// Any frees not yet in a batch
	always_comb begin
		any_open = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (((bc_q != '0) ? last_q[c] : head_q[c]) != tail_q[c]) any_open = 1'b1;
		end
	end

	// Status to the controller
	assign stat.clr_last       = (clr_addr_q == AW'(MEM_DEPTH - 1));
	assign stat.act            = act_q;
	assign stat.alloc_recycled = recyc;
	assign stat.bc_zero        = (bc_q == '0);
	assign stat.ret_more       = head_q[rcls_q] != marks_q[0][rcls_q];
	assign stat.ret_last_cls   = rcls_q == CW'(NUM_CLASSES - 1);

	// Memory addressing
	assign stk_raddr  = mem_addr(ci, rc_dec[SW-1:0]);
	assign fifo_raddr = mem_addr(rcls_q, head_q[rcls_q][SW-1:0]);
	assign bm_raddr   = mem_addr(ci, slot_q);

	assign stk_we     = cmd.ret_wr && ret_room;
	assign stk_waddr  = mem_addr(rcls_q, rc_q[rcls_q][SW-1:0]);
	assign fifo_we    = cmd.free_fin && !bad;
	assign fifo_waddr = mem_addr(ci, tail_q[ci][SW-1:0]);

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = clr_addr_q;
		bm_wdata = 1'b0;
		if (cmd.clear_step) begin
			bm_we = 1'b1;
		end else if (cmd.alloc_exec && do_fresh) begin
			bm_we    = 1'b1;
			bm_waddr = mem_addr(ci, cand[SW-1:0]);
			bm_wdata = 1'b1;
		end else if (cmd.alloc_fin) begin
			bm_we    = 1'b1;
			bm_waddr = mem_addr(ci, stk_rd_q);
			bm_wdata = 1'b1;
		end else if (cmd.free_fin && !bad) begin
			bm_we    = 1'b1;
			bm_waddr = mem_addr(ci, slot_q);
		end
	end

	// Recycled stacks
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= fifo_rd_q;
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// Pending FIFOs
	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_waddr] <= slot_q;
		fifo_rd_q <= fifo_mem[fifo_raddr];
	end

	// Allocated bitmap
	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
		bm_rd_q <= bm_mem[bm_raddr];
	end

	// Input word capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q    <= action;
			cls_q    <= pool_class;
			slot_q   <= slot;
			handle_q <= resource_handle;
			samp_q   <= sampler_code;
		end
	end

	// Batch marks: append on commit, shift out oldest on retire
	always_ff @(posedge clk) begin
		if (do_commit) begin
			for (int c = 0; c < NUM_CLASSES; c++) marks_q[bc_q[IW-1:0]][c] <= tail_q[c];
		end else if (cmd.ret_fin) begin
			for (int b = 0; b < MAX_BATCHES - 1; b++) marks_q[b] <= marks_q[b+1];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= '0;
			rc_q       <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			last_q     <= '0;
			bc_q       <= '0;
			rcls_q     <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.clear_step) clr_addr_q <= clr_addr_q + AW'(1);
			if (cmd.alloc_exec) begin
				if (recyc)         rc_q[ci]    <= rc_dec;
				else if (do_fresh) fresh_q[ci] <= fresh_q[ci] + CNT_W'(1);
			end
			if (cmd.free_fin && !bad) tail_q[ci] <= tail_q[ci] + PW'(1);
			if (do_commit) begin
				last_q <= tail_q;
				bc_q   <= bc_q + BW'(1);
			end
			if (cmd.ret_start) rcls_q <= '0;
			if (cmd.ret_next)  rcls_q <= rcls_q + CW'(1);
			if (cmd.ret_rd)    head_q[rcls_q] <= head_q[rcls_q] + PW'(1);
			if (stk_we)        rc_q[rcls_q] <= rc_q[rcls_q] + CNT_W'(1);
			if (cmd.ret_fin)   bc_q <= bc_q - BW'(1);
		end
	end

	// Result word
	always_comb begin
		emit     = 1'b0;
		r_status = ST_OK;
		r_slot   = '0;
		r_op     = TOP_NONE;
		r_cls    = '0;
		r_handle = '0;
		r_samp   = '0;
		if ((cmd.alloc_exec && !recyc) || cmd.alloc_fin) begin
			emit = 1'b1;
			if (cmd.alloc_fin || do_fresh) begin
				r_slot   = cmd.alloc_fin ? stk_rd_q : cand[SW-1:0];
				r_op     = TOP_BIND;
				r_cls    = cls_q;
				r_handle = handle_q;
				r_samp   = (cls_q == '0) ? '0 : samp_q;
			end else begin
				r_status = ST_EMPTY;
			end
		end else if (cmd.free_fin) begin
			emit   = 1'b1;
			r_slot = slot_q;
			if (bad) begin
				r_status = ST_BADFREE;
			end else begin
				r_op  = TOP_UNBIND;
				r_cls = cls_q;
			end
		end else if (cmd.commit) begin
			emit     = 1'b1;
			r_status = (any_open && bc_full) ? ST_QFULL : ST_OK;
		end else if (cmd.ret_empty) begin
			emit     = 1'b1;
			r_status = ST_NORET;
		end else if (cmd.ret_fin) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status       <= r_status;
			out_slot     <= r_slot;
			table_op     <= r_op;
			table_class  <= r_cls;
			bind_handle  <= r_handle;
			bind_sampler <= r_samp;
		end
	end

endmodule

[rtl/deferred_slot_allocator_unit.sv]
`timescale 1ns / 1ps
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+---------------------------------------
// command   | start, busy: taken when start&!busy | action, pool_class, slot,
//           |                                    | resource_handle, sampler_code
// result    | done: one-cycle strobe             | status, out_slot, table_op, table_class,
//           |                                    | bind_handle, bind_sampler
// config    | APB write when psel&penable&pwrite | paddr, pwdata, prdata; pready tied high
//
// From accept to done: commit and allocate (fresh or empty) pass S_EXEC; a recycled
// allocate adds S_ALLOC_WB, a free adds S_FREE_FIN (bitmap read then update), and
// retire has the controller walk each pool's pending FIFO an entry at a time, through
// S_RET_CHK and S_RET_WR. After reset the allocated bitmap is cleared one entry a
// cycle, with busy high until it is done. Config writes are taken at any time.
// The receiver cannot stall: done flags each word for one cycle.
module deferred_slot_allocator_unit #(
	parameter int MAX_BATCHES = dsa_pkg::DEF_MAX_BATCHES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [1:0]  pool_class,
	input  logic [9:0]  slot,
	input  logic [63:0] resource_handle,
	input  logic [7:0]  sampler_code,
	output logic        done,
	output logic [2:0]  status,
	output logic [9:0]  out_slot,
	output logic [1:0]  table_op,
	output logic [1:0]  table_class,
	output logic [63:0] bind_handle,
	output logic [7:0]  bind_sampler,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dsa_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	dsa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	dsa_datapath #(.MAX_BATCHES(MAX_BATCHES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.pool_class      (pool_class),
		.slot            (slot),
		.resource_handle (resource_handle),
		.sampler_code    (sampler_code),
		.done            (done),
		.status          (status),
		.out_slot        (out_slot),
		.table_op        (table_op),
		.table_class     (table_class),
		.bind_handle     (bind_handle),
		.bind_sampler    (bind_sampler)
	);

endmodule

[rtl/dsa_checker.sv]
`timescale 1ns / 1ps
module dsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [1:0]  table_op,
	input logic [1:0]  table_class,
	input logic [7:0]  bind_sampler
);
	import dsa_pkg::*;

	// A word only comes out of work that was under way
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in flight");

	// An accepted command keeps the unit busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but unit not busy");

	// Table commands only with a good status
	a_op_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_op != TOP_NONE) |-> status == ST_OK)
		else $error("table command with error status");

	// Sampler only travels with image or volume binds
	a_samp_bind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bind_sampler != 8'd0) |-> (table_op == TOP_BIND && table_class != 2'd0))
		else $error("sampler outside an image or volume bind");

endmodule

bind deferred_slot_allocator_unit dsa_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.table_op     (table_op),
	.table_class  (table_class),
	.bind_sampler (bind_sampler)
);

[tb/sv/slot_alloc_checker.sv]
`timescale 1ns / 1ps
module slot_alloc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [1:0]  pool_class,
	input  logic [9:0]  slot,
	input  logic [63:0] resource_handle,
	input  logic [7:0]  sampler_code,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [9:0]  out_slot,
	input  logic [1:0]  table_op,
	input  logic [1:0]  table_class,
	input  logic [63:0] bind_handle,
	input  logic [7:0]  bind_sampler,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          words_owed,
	output int          fail_count
);
	import dsa_pkg::*;

	localparam int NB   = DEF_MAX_BATCHES;
	localparam int SPAN = 2 * SLOTS;

	typedef struct {
		logic [2:0]  st;
		logic [9:0]  slot_no;
		logic [1:0]  op;
		logic [1:0]  cls;
		logic [63:0] handle;
		logic [7:0]  sampler;
	} slot_word_t;

	// Mirrored registers
	logic [SIZE_W-1:0] size_reg [NUM_CLASSES];
	logic [RSV_W-1:0]  rsv_reg  [NUM_CLASSES];

	// Mirrored allocator state
	int         fresh_cnt [NUM_CLASSES];
	logic [9:0] lifo      [NUM_CLASSES][SLOTS];
	int         lifo_cnt  [NUM_CLASSES];
	logic [9:0] pend      [NUM_CLASSES][SLOTS];
	int         pend_head [NUM_CLASSES];
	int         pend_tail [NUM_CLASSES];
	int         marks     [NB][NUM_CLASSES];
	int         nbatch;
	bit         owned     [NUM_CLASSES][SLOTS];

	slot_word_t owed_q[$];

	function automatic int ring_dist(int from, int to);
		return (to + SPAN - from) % SPAN;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Expected word for one command; updates the mirrored state
	task automatic predict_slot_word(output slot_word_t w);
		int c, lim, cand, base, s;
		bit any;
		w = '{default: '0};
		c = pool_class;
		case (action)
		ACT_ALLOC: begin
			if (c >= NUM_CLASSES) begin
				w.st = ST_EMPTY;
				return;
			end
			if (lifo_cnt[c] > 0) begin
				lifo_cnt[c]--;
				s = lifo[c][lifo_cnt[c]];
			end else begin
				lim = (size_reg[c] > SLOTS) ? SLOTS : size_reg[c];
				cand = rsv_reg[c] + fresh_cnt[c];
				if (cand >= lim) begin
					w.st = ST_EMPTY;
					return;
				end
				s = cand;
				fresh_cnt[c]++;
			end
			owned[c][s] = 1;
			w.slot_no = 10'(s);
			w.op = TOP_BIND;
			w.cls = 2'(c);
			w.handle = resource_handle;
			w.sampler = (c == 0) ? 8'd0 : sampler_code;
		end
		ACT_FREE: begin
			w.slot_no = slot;
			if (c >= NUM_CLASSES || !owned[c][slot] ||
				ring_dist(pend_head[c], pend_tail[c]) >= SLOTS) begin
				w.st = ST_BADFREE;
				return;
			end
			owned[c][slot] = 0;
			pend[c][pend_tail[c] % SLOTS] = slot;
			pend_tail[c] = (pend_tail[c] + 1) % SPAN;
			w.op = TOP_UNBIND;
			w.cls = 2'(c);
		end
		ACT_COMMIT: begin
			any = 0;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				base = nbatch ? marks[nbatch-1][k] : pend_head[k];
				if (ring_dist(base, pend_tail[k]) != 0) any = 1;
			end
			if (!any) return;
			if (nbatch >= NB) begin
				w.st = ST_QFULL;
				return;
			end
			for (int k = 0; k < NUM_CLASSES; k++) marks[nbatch][k] = pend_tail[k];
			nbatch++;
		end
		default: begin
			if (nbatch == 0) begin
				w.st = ST_NORET;
				return;
			end
			for (int k = 0; k < NUM_CLASSES; k++) begin
				while (pend_head[k] != marks[0][k]) begin
					if (lifo_cnt[k] < SLOTS) begin
						lifo[k][lifo_cnt[k]] = pend[k][pend_head[k] % SLOTS];
						lifo_cnt[k]++;
					end
					pend_head[k] = (pend_head[k] + 1) % SPAN;
				end
			end
			for (int b = 1; b < nbatch; b++) marks[b-1] = marks[b];
			nbatch--;
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_word_t w, got;
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				size_reg[k] = SIZE_W'(SLOTS);
				rsv_reg[k] = '0;
				fresh_cnt[k] = 0;
				lifo_cnt[k] = 0;
				pend_head[k] = 0;
				pend_tail[k] = 0;
				for (int j = 0; j < SLOTS; j++) owned[k][j] = 0;
			end
			nbatch = 0;
			owed_q.delete();
			words_owed = 0;
			fail_count = 0;
		end else begin
			// Result side first: a word never belongs to a command taken at the same edge
			if (done) begin
				got = '{status, out_slot, table_op, table_class, bind_handle, bind_sampler};
				if (owed_q.size() == 0) begin
					$display("unexpected result word at %0t", $time);
					fail_count++;
				end else begin
					w = owed_q.pop_front();
					if (got.st !== w.st) report_mismatch("status", got.st, w.st);
					if (got.slot_no !== w.slot_no)
						report_mismatch("out_slot", got.slot_no, w.slot_no);
					if (got.op !== w.op) report_mismatch("table_op", got.op, w.op);
					if (got.cls !== w.cls) report_mismatch("table_class", got.cls, w.cls);
					if (got.handle !== w.handle)
						report_mismatch("bind_handle", got.handle, w.handle);
					if (got.sampler !== w.sampler)
						report_mismatch("bind_sampler", got.sampler, w.sampler);
				end
			end
			if (start && !busy) begin
				predict_slot_word(w);
				owed_q.push_back(w);
			end
			// Register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[4:2] < NUM_CLASSES) size_reg[paddr[4:2]] = pwdata[SIZE_W-1:0];
				else if (paddr[4:2] < 2 * NUM_CLASSES)
					rsv_reg[paddr[4:2] - NUM_CLASSES] = pwdata[RSV_W-1:0];
			end
			words_owed = owed_q.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import dsa_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 150;

	logic        clk, arst_n, start, busy, done, pready;
	logic [1:0]  action, pool_class, table_op, table_class;
	logic [9:0]  slot, out_slot;
	logic [63:0] resource_handle, bind_handle;
	logic [7:0]  sampler_code, bind_sampler;
	logic [2:0]  status;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          words_owed, fail_count, quiet_cycles;
	bit          allow_gaps;

	deferred_slot_allocator_unit dut (.*);

	slot_alloc_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] act, input logic [1:0] cls,
		input logic [9:0] sl, input logic [63:0] h, input logic [7:0] smp);
		@(negedge clk);
		action = act;
		pool_class = cls;
		slot = sl;
		resource_handle = h;
		sampler_code = smp;
		start = 1;
		do @(posedge clk); while (busy);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start = 0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		start = 0;
		while (words_owed != 0 || busy) @(negedge clk);
	endtask

	task automatic reg_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = 5'(4 * idx);
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic random_word;
		int r;
		logic [1:0] cls;
		logic [9:0] sl;
		r = $urandom_range(0, 99);
		cls = ($urandom_range(0, 29) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		sl = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
		send_word(r < 40 ? ACT_ALLOC : r < 74 ? ACT_FREE : r < 88 ? ACT_COMMIT : ACT_RETIRE,
			cls, sl, {$urandom, $urandom}, 8'($urandom));
	endtask

	initial begin
		logic [31:0] v;
		arst_n = 0;
		start = 0;
		action = ACT_ALLOC;
		pool_class = 0;
		slot = 0;
		resource_handle = 0;
		sampler_code = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		allow_gaps = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: nothing to retire, empty commit, bad frees, binds on every pool
		send_word(ACT_RETIRE, 0, 0, 0, 0);
		send_word(ACT_COMMIT, 0, 0, 0, 0);
		send_word(ACT_FREE, 0, 10'h3ff, 0, 0);
		send_word(ACT_FREE, 3, 0, 0, 0);
		send_word(ACT_ALLOC, 3, 0, '1, '1);
		send_word(ACT_ALLOC, 0, 0, '1, '1);
		send_word(ACT_ALLOC, 1, 0, 64'h0123_4567_89ab_cdef, 8'ha5);
		send_word(ACT_ALLOC, 2, 0, 0, 8'h5a);
		send_word(ACT_ALLOC, 2, 0, '1, 8'hff);
		send_word(ACT_FREE, 0, 0, 0, 0);
		send_word(ACT_FREE, 0, 0, 0, 0);
		send_word(ACT_FREE, 2, 1, 0, 0);
		send_word(ACT_COMMIT, 0, 0, 0, 0);
		send_word(ACT_COMMIT, 0, 0, 0, 0);
		send_word(ACT_FREE, 1, 0, 0, 0);
		send_word(ACT_COMMIT, 0, 0, 0, 0);
		send_word(ACT_RETIRE, 0, 0, 0, 0);
		send_word(ACT_ALLOC, 2, 0, 64'h8000_0000_0000_0001, 8'h01);
		send_word(ACT_ALLOC, 0, 0, 64'h55, 0);
		send_word(ACT_RETIRE, 0, 0, 0, 0);
		send_word(ACT_ALLOC, 1, 0, 64'haa, 8'h80);
		send_word(ACT_RETIRE, 0, 0, 0, 0);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			for (int i = 0; i < 2 * NUM_CLASSES; i++) begin
				if (i < NUM_CLASSES) begin
					if (ph == 0) v = (i == 0) ? 0 : (i == 1) ? SLOTS : 2047;
					else case ($urandom_range(0, 5))
						0: v = 0;
						1: v = SLOTS;
						2: v = 2047;
						default: v = $urandom_range(1, 48);
					endcase
				end else begin
					if (ph == 0) v = (i == NUM_CLASSES) ? 1023 : 0;
					else case ($urandom_range(0, 5))
						0: v = 1023;
						1: v = 0;
						default: v = $urandom_range(0, 16);
					endcase
				end
				reg_write(i, v);
			end
			allow_gaps = (ph < PHASES - 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// Hold off mid-phase until every owed word is back
				if (ph == 3 && n == PHASE_WORDS / 2) drain();
				random_word();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
